@@ rtl/core/ibbf_pkg.sv @@
package ibbf_pkg;

	// largest frame side, larger register values are clipped to it
	localparam int MAX_DIM = 1024;

	// pixel channel level that means paper, not ink
	localparam logic [7:0] WHITE_LEVEL = 8'hFF;

	localparam int CHAN_W = 8;
	localparam int DIM_W  = 11;
	localparam int BOX_X_W = 11;
	localparam int BOX_Y_W = 10;
	localparam int BOX_W_W = 11;
	localparam int BOX_H_W = 11;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;
	localparam int M_PAD_W   = M_TDATA_W - BOX_X_W - BOX_Y_W - BOX_W_W - BOX_H_W;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 11'd64;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 11'd64;

	typedef struct packed {
		logic valid;
		logic ink;
	} pix_t;

	typedef struct packed {
		logic [BOX_X_W-1:0] box_x;
		logic [BOX_Y_W-1:0] box_y;
		logic [BOX_W_W-1:0] box_w;
		logic [BOX_H_W-1:0] box_h;
	} box_t;

	typedef struct packed {
		logic load;
		box_t box;
	} res_t;

endpackage

@@ rtl/core/ink_bounding_box_finder_unit.sv @@
// Ink bounding box finder: takes one RGB pixel per clock in raster order over a frame of
// frame_width by frame_height pixels (register 0 and 1 on the cfg port, 0 counts as 1 and
// values above 1024 count as 1024) and, on the last pixel of each frame, returns one
// result with the box around every pixel that is not pure white: box_x the leftmost ink
// column, box_y the first ink row, box_w the last ink column minus box_x, and box_h the
// latest blank row that follows an ink row (or the height) minus box_y. A blank frame gives
// box_x equal to the width, box_y 0, box_w the negated width and box_h the height. The block
// sustains one pixel per clock: a pixel register feeds the running min/max tracker, whose
// update is combinational compares, and the box lands in an output register as the tracker
// takes the last pixel in. While a box waits on m_tready the block keeps taking pixels
// of the next frame and only stalls on the last pixel of that frame. Write the registers
// only while no pixel is in flight; they take effect on the next pixel.
module ink_bounding_box_finder_unit (
	input  logic                              clk,
	input  logic                              arst_n,

	// pixel request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ibbf_pkg::S_TDATA_W-1:0]    s_tdata,   // red [7:0], green [15:8], blue [23:16]

	// box result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ibbf_pkg::M_TDATA_W-1:0]    m_tdata,   // box_x, box_y, box_w, box_h, zero pad

	// register write port
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ibbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ibbf_pkg::DIM_W-1:0]        cfg_data
);

	logic [ibbf_pkg::DIM_W-1:0] frame_width_q;
	logic [ibbf_pkg::DIM_W-1:0] frame_height_q;

	ibbf_pkg::pix_t pix;
	ibbf_pkg::res_t res;
	logic           advance;
	logic           out_free;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ibbf_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= ibbf_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ibbf_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				ibbf_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// pixel register with ink classification
	ibbf_pixel_in u_pixel_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.pix      (pix)
	);

	// column / row counters and running extents
	ibbf_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.out_free     (out_free),
		.advance      (advance),
		.res          (res)
	);

	// result register toward the consumer
	ibbf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ rtl/core/ibbf_pixel_in.sv @@
module ibbf_pixel_in (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ibbf_pkg::S_TDATA_W-1:0]  s_tdata,  // red, green, blue from bit 0 up
	input  logic                            advance,
	output ibbf_pkg::pix_t                  pix
);

	logic valid_s1;
	logic ink_s1;
	logic ink;

	// ink unless all three channels are white
	assign ink = !(s_tdata[7:0] == ibbf_pkg::WHITE_LEVEL &&
		s_tdata[15:8] == ibbf_pkg::WHITE_LEVEL &&
		s_tdata[23:16] == ibbf_pkg::WHITE_LEVEL);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ink_s1 <= ink;
		end
	end

	assign pix.valid = valid_s1;
	assign pix.ink   = ink_s1;

endmodule

@@ rtl/core/ibbf_tracker.sv @@
module ibbf_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ibbf_pkg::pix_t              pix,
	input  logic [ibbf_pkg::DIM_W-1:0]  frame_width,
	input  logic [ibbf_pkg::DIM_W-1:0]  frame_height,
	input  logic                        out_free,
	output logic                        advance,
	output ibbf_pkg::res_t              res
);

	localparam int CW = $clog2(ibbf_pkg::MAX_DIM);
	localparam int DW = $clog2(ibbf_pkg::MAX_DIM + 1);
	localparam int EW = (DW > ibbf_pkg::DIM_W) ? DW : ibbf_pkg::DIM_W;
	localparam logic [EW-1:0] MAX_E = EW'(ibbf_pkg::MAX_DIM);
	localparam logic [DW-1:0] MAX_D = DW'(ibbf_pkg::MAX_DIM);

	logic [CW-1:0] col_q, row_q, max_q, first_row_q, bottom_q;
	logic [DW-1:0] min_q;
	logic          row_ink_q, prev_blank_q, first_found_q, bottom_found_q;

	logic [EW-1:0] w_ext, h_ext, w_clip, h_clip;
	logic [DW-1:0] w_eff, h_eff;
	logic          row_end, frame_end, row_ink;

	logic [CW-1:0] max_n, first_row_n, bottom_n;
	logic [DW-1:0] min_n;
	logic          first_found_n, bottom_found_n;

	logic [DW-1:0] x_sel;
	logic [CW-1:0] y_sel;
	logic [DW-1:0] bottom_sel;
	logic [EW-1:0] w_diff, h_diff, x_ext, y_ext;

	// zero counts as one, above the limit counts as the limit
	assign w_ext  = EW'(frame_width);
	assign h_ext  = EW'(frame_height);
	assign w_clip = (w_ext == '0) ? EW'(1) : ((w_ext > MAX_E) ? MAX_E : w_ext);
	assign h_clip = (h_ext == '0) ? EW'(1) : ((h_ext > MAX_E) ? MAX_E : h_ext);
	assign w_eff  = w_clip[DW-1:0];
	assign h_eff  = h_clip[DW-1:0];

	assign row_end   = !(EW'(col_q) + EW'(1) < EW'(w_eff));
	assign frame_end = row_end && !(EW'(row_q) + EW'(1) < EW'(h_eff));
	assign row_ink   = row_ink_q || pix.ink;

	assign advance = pix.valid && (!frame_end || out_free);

	always_comb begin
		min_n          = min_q;
		max_n          = max_q;
		first_row_n    = first_row_q;
		first_found_n  = first_found_q;
		bottom_n       = bottom_q;
		bottom_found_n = bottom_found_q;
		if (pix.ink) begin
			if (DW'(col_q) < min_q) begin
				min_n = DW'(col_q);
			end
			if (col_q > max_q) begin
				max_n = col_q;
			end
		end
		if (row_end) begin
			if (row_ink) begin
				if (!first_found_q) begin
					first_row_n   = row_q;
					first_found_n = 1'b1;
				end
			end else if (!prev_blank_q) begin
				bottom_n       = row_q;
				bottom_found_n = 1'b1;
			end
		end
	end

	// box from the values that include this last pixel
	assign x_sel      = first_found_n ? min_n : w_eff;
	assign y_sel      = first_found_n ? first_row_n : '0;
	assign bottom_sel = bottom_found_n ? DW'(bottom_n) : h_eff;
	assign x_ext      = EW'(x_sel);
	assign y_ext      = EW'(y_sel);
	assign w_diff     = EW'(max_n) - x_ext;
	assign h_diff     = EW'(bottom_sel) - y_ext;

	assign res.load      = advance && frame_end;
	assign res.box.box_x = x_ext[ibbf_pkg::BOX_X_W-1:0];
	assign res.box.box_y = y_ext[ibbf_pkg::BOX_Y_W-1:0];
	assign res.box.box_w = w_diff[ibbf_pkg::BOX_W_W-1:0];
	assign res.box.box_h = h_diff[ibbf_pkg::BOX_H_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= '0;
			row_q          <= '0;
			row_ink_q      <= 1'b0;
			prev_blank_q   <= 1'b1;
			min_q          <= MAX_D;
			max_q          <= '0;
			first_row_q    <= '0;
			first_found_q  <= 1'b0;
			bottom_q       <= '0;
			bottom_found_q <= 1'b0;
		end else if (advance) begin
			if (frame_end) begin
				col_q          <= '0;
				row_q          <= '0;
				row_ink_q      <= 1'b0;
				prev_blank_q   <= 1'b1;
				min_q          <= MAX_D;
				max_q          <= '0;
				first_row_q    <= '0;
				first_found_q  <= 1'b0;
				bottom_q       <= '0;
				bottom_found_q <= 1'b0;
			end else begin
				min_q          <= min_n;
				max_q          <= max_n;
				first_row_q    <= first_row_n;
				first_found_q  <= first_found_n;
				bottom_q       <= bottom_n;
				bottom_found_q <= bottom_found_n;
				if (row_end) begin
					col_q        <= '0;
					row_q        <= row_q + CW'(1);
					row_ink_q    <= 1'b0;
					prev_blank_q <= !row_ink;
				end else begin
					col_q     <= col_q + CW'(1);
					row_ink_q <= row_ink;
				end
			end
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |=> col_q == '0 && row_q == '0 && !first_found_q && !bottom_found_q)
		else $error("tracker state not cleared after frame end");

	a_bottom_after_ink: assert property (@(posedge clk) disable iff (!arst_n)
		bottom_found_q |-> first_found_q)
		else $error("bottom row found before any ink row");

	a_found_has_column: assert property (@(posedge clk) disable iff (!arst_n)
		first_found_q |-> min_q < MAX_D)
		else $error("ink row found without an ink column");

endmodule

@@ rtl/core/ibbf_out_reg.sv @@
module ibbf_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ibbf_pkg::res_t                  res,
	output logic                            out_free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ibbf_pkg::M_TDATA_W-1:0]  m_tdata  // box_x, box_y, box_w, box_h from bit 0 up
);

	logic           valid_q;
	ibbf_pkg::box_t box_q;

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			box_q <= res.box;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{ibbf_pkg::M_PAD_W{1'b0}}, box_q.box_h, box_q.box_w,
		box_q.box_y, box_q.box_x};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> !valid_q || m_tready)
		else $error("result loaded over one not yet taken");

endmodule

@@ tb/ibbf_box_checker.sv @@
`timescale 1ns / 1ps

module ibbf_box_checker (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [ibbf_pkg::S_TDATA_W-1:0]    s_tdata,   // red [7:0], green [15:8], blue [23:16]

	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ibbf_pkg::M_TDATA_W-1:0]    m_tdata,   // box_x, box_y, box_w, box_h, zero pad

	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ibbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ibbf_pkg::DIM_W-1:0]        cfg_data,

	output int unsigned                       fail_count,
	output int unsigned                       pending_count
);

	localparam int Y_LSB = ibbf_pkg::BOX_X_W;
	localparam int W_LSB = Y_LSB + ibbf_pkg::BOX_Y_W;
	localparam int H_LSB = W_LSB + ibbf_pkg::BOX_W_W;
	localparam int MAX_REPORTS = 10;
	localparam int unsigned DIM_LIMIT = ibbf_pkg::MAX_DIM;
	localparam int DUE_AW = 4;
	localparam int DUE_DEPTH = 1 << DUE_AW;

	logic [ibbf_pkg::DIM_W-1:0] width_reg;
	logic [ibbf_pkg::DIM_W-1:0] height_reg;

	// running box of the frame in progress
	logic [31:0] col_pos;
	logic [31:0] row_pos;
	logic [31:0] left_col;
	logic [31:0] right_col;
	logic [31:0] top_row;
	logic [31:0] bottom_row;
	logic        row_inked;
	logic        prev_row_blank;
	logic        top_seen;
	logic        bottom_seen;

	// predicted boxes waiting for the output side
	ibbf_pkg::box_t    due_ring[DUE_DEPTH];
	logic [DUE_AW-1:0] due_wr;
	logic [DUE_AW-1:0] due_rd;
	int unsigned       due_count;

	ibbf_pkg::box_t got_box;
	ibbf_pkg::box_t want_box;
	int unsigned    mismatches;

	function automatic logic [31:0] fit_dim(input logic [ibbf_pkg::DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return 32'(v);
	endfunction

	task automatic clear_frame();
		col_pos        = 0;
		row_pos        = 0;
		row_inked      = 1'b0;
		prev_row_blank = 1'b1;
		left_col       = DIM_LIMIT;
		right_col      = 0;
		top_row        = 0;
		top_seen       = 1'b0;
		bottom_row     = 0;
		bottom_seen    = 1'b0;
	endtask

	task automatic track_pixel(input logic [ibbf_pkg::S_TDATA_W-1:0] px);
		logic [31:0]    wd;
		logic [31:0]    ht;
		logic [31:0]    x0;
		logic [31:0]    y0;
		logic [31:0]    bot;
		logic [31:0]    dx;
		logic [31:0]    dy;
		logic           ink;
		ibbf_pkg::box_t b;
		wd  = fit_dim(width_reg);
		ht  = fit_dim(height_reg);
		ink = !(px[7:0] == ibbf_pkg::WHITE_LEVEL && px[15:8] == ibbf_pkg::WHITE_LEVEL &&
			px[23:16] == ibbf_pkg::WHITE_LEVEL);
		if (ink) begin
			if (col_pos < left_col)
				left_col = col_pos;
			if (col_pos > right_col)
				right_col = col_pos;
			row_inked = 1'b1;
		end
		if (col_pos + 1 < wd) begin
			col_pos = col_pos + 1;
		end else begin
			// row done: first inked row, or a blank row right below ink
			if (row_inked) begin
				if (!top_seen) begin
					top_row  = row_pos;
					top_seen = 1'b1;
				end
			end else if (!prev_row_blank) begin
				bottom_row  = row_pos;
				bottom_seen = 1'b1;
			end
			prev_row_blank = !row_inked;
			row_inked      = 1'b0;
			col_pos        = 0;
			if (row_pos + 1 < ht) begin
				row_pos = row_pos + 1;
			end else begin
				x0  = top_seen ? left_col : wd;
				y0  = top_seen ? top_row : 0;
				bot = bottom_seen ? bottom_row : ht;
				dx  = right_col - x0;
				dy  = bot - y0;
				b.box_x = x0[ibbf_pkg::BOX_X_W-1:0];
				b.box_y = y0[ibbf_pkg::BOX_Y_W-1:0];
				b.box_w = dx[ibbf_pkg::BOX_W_W-1:0];
				b.box_h = dy[ibbf_pkg::BOX_H_W-1:0];
				due_ring[due_wr] = b;
				due_wr           = due_wr + DUE_AW'(1);
				due_count++;
				clear_frame();
			end
		end
	endtask

	task automatic note_mismatch(input string what, input ibbf_pkg::box_t want,
			input ibbf_pkg::box_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected x=%0d y=%0d w=%0d h=%0d, got x=%0d y=%0d w=%0d h=%0d",
				$realtime, what, want.box_x, want.box_y, $signed(want.box_w), want.box_h,
				got.box_x, got.box_y, $signed(got.box_w), got.box_h);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = ibbf_pkg::FRAME_WIDTH_RESET;
			height_reg = ibbf_pkg::FRAME_HEIGHT_RESET;
			clear_frame();
			due_wr     = '0;
			due_rd     = '0;
			due_count  = 0;
			mismatches = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_box.box_x = m_tdata[Y_LSB-1:0];
				got_box.box_y = m_tdata[W_LSB-1:Y_LSB];
				got_box.box_w = m_tdata[H_LSB-1:W_LSB];
				got_box.box_h = m_tdata[H_LSB+ibbf_pkg::BOX_H_W-1:H_LSB];
				if (due_count == 0) begin
					note_mismatch("box with none expected", '0, got_box);
				end else begin
					want_box = due_ring[due_rd];
					due_rd   = due_rd + DUE_AW'(1);
					due_count--;
					if (got_box.box_x != want_box.box_x || got_box.box_y != want_box.box_y ||
						got_box.box_w != want_box.box_w || got_box.box_h != want_box.box_h)
						note_mismatch("box mismatch", want_box, got_box);
				end
			end
			// a register write lands before the next pixel is taken
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ibbf_pkg::REG_FRAME_WIDTH:  width_reg = cfg_data;
					ibbf_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				track_pixel(s_tdata);
			fail_count    <= mismatches;
			pending_count <= due_count;
		end
	end

endmodule

@@ tb/ink_bounding_box_finder_unit_tb.sv @@
`timescale 1ns / 1ps

module ink_bounding_box_finder_unit_tb;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	// margin after the last box drains
	localparam int DRAIN_CYCLES  = 12;
	localparam int DRAIN_LIMIT   = 20000;
	localparam longint LIMIT_NS  = 2000000;
	localparam int PW            = ibbf_pkg::S_TDATA_W;
	localparam int DW            = ibbf_pkg::DIM_W;
	localparam int IW            = ibbf_pkg::CFG_IDX_W;
	localparam int RANDOM_PIXELS = 120;
	localparam logic [PW-1:0] WHITE_PIXEL = {3{ibbf_pkg::WHITE_LEVEL}};

	typedef enum logic [1:0] {
		INK_SCATTER,
		INK_NONE,
		INK_CORNERS,
		INK_LAST_ONLY
	} ink_layout_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic [PW-1:0]                     s_tdata   = '0;
	logic                              m_tready  = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic [IW-1:0]                     cfg_index = ibbf_pkg::REG_FRAME_WIDTH;
	logic [DW-1:0]                     cfg_data  = '0;

	wire                               s_tready;
	wire                               m_tvalid;
	wire [ibbf_pkg::M_TDATA_W-1:0]     m_tdata;
	wire                               cfg_ready;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned pixels_sent   = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	ink_bounding_box_finder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ibbf_box_checker watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// box receiver stalls at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [PW-1:0] rgb(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {b, g, r};
	endfunction

	// any pixel that is not pure white: random, near white or black
	function automatic logic [PW-1:0] ink_pixel();
		logic [PW-1:0] px;
		int unsigned   sel;
		px = PW'($urandom());
		case ($urandom_range(3))
			1: begin
				sel = $urandom_range(2);
				px  = WHITE_PIXEL;
				px[sel*8 +: 8] = 8'($urandom_range(254));
			end
			2: px = '0;
			default: ;
		endcase
		if (px == WHITE_PIXEL)
			px[7:0] = 8'($urandom_range(254));
		return px;
	endfunction

	// one pixel request, with random idle cycles ahead of it
	task automatic send_pixel(input logic [PW-1:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// stop pixels and let every box drain before touching the registers
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [DW-1:0] wv, input logic [DW-1:0] hv);
		settle();
		write_reg(ibbf_pkg::REG_FRAME_WIDTH, wv);
		write_reg(ibbf_pkg::REG_FRAME_HEIGHT, hv);
	endtask

	// whole frame of the given effective size
	task automatic send_frame(input int unsigned w, input int unsigned h,
			input ink_layout_t layout);
		int unsigned ink_pct;
		bit          blank_row;
		bit          ink;
		ink_pct = $urandom_range(5, 95);
		for (int unsigned r = 0; r < h; r++) begin
			blank_row = ($urandom_range(2) == 0);
			for (int unsigned c = 0; c < w; c++) begin
				case (layout)
					INK_NONE:      ink = 1'b0;
					INK_CORNERS:   ink = (r == 0 && c == 0) || (r == h - 1 && c == w - 1);
					INK_LAST_ONLY: ink = (r == h - 1 && c == w - 1);
					default:       ink = !blank_row && ($urandom_range(99) < ink_pct);
				endcase
				send_pixel(ink ? ink_pixel() : WHITE_PIXEL);
			end
		end
	endtask

	// small frame, sometimes written as zero when the size is one
	task automatic random_frame();
		int unsigned   w;
		int unsigned   h;
		logic [DW-1:0] wv;
		logic [DW-1:0] hv;
		ink_layout_t   layout;
		w  = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		h  = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
		wv = (w == 1 && $urandom_range(1)) ? '0 : DW'(w);
		hv = (h == 1 && $urandom_range(1)) ? '0 : DW'(h);
		case ($urandom_range(15))
			0, 1:    layout = INK_NONE;
			2:       layout = INK_CORNERS;
			3:       layout = INK_LAST_ONLY;
			default: layout = INK_SCATTER;
		endcase
		set_frame(wv, hv);
		send_frame(w, h, layout);
	endtask

	// frame cut short by a register change; a 1x1 size then closes it with one pixel
	task automatic broken_frame();
		int unsigned w;
		int unsigned h;
		int unsigned n;
		w = $urandom_range(2, 8);
		h = $urandom_range(2, 8);
		set_frame(DW'(w), DW'(h));
		n = $urandom_range(1, w * h - 1);
		repeat (n) send_pixel($urandom_range(1) ? ink_pixel() : WHITE_PIXEL);
		settle();
		write_reg($urandom_range(1) ? ibbf_pkg::REG_FRAME_HEIGHT : ibbf_pkg::REG_FRAME_WIDTH,
			DW'($urandom_range(1, 8)));
		n = $urandom_range(0, 6);
		repeat (n) send_pixel($urandom_range(1) ? ink_pixel() : WHITE_PIXEL);
		settle();
		write_reg(ibbf_pkg::REG_FRAME_WIDTH, DW'(1));
		write_reg(ibbf_pkg::REG_FRAME_HEIGHT, DW'(1));
		send_pixel($urandom_range(1) ? ink_pixel() : WHITE_PIXEL);
	endtask

	initial begin
		int unsigned px0;
		int unsigned ph;
		int unsigned waited;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 64 by 64: one full row, then a height of one closes the frame on the next
		repeat (64) send_pixel(($urandom_range(3) == 0) ? ink_pixel() : WHITE_PIXEL);
		settle();
		write_reg(ibbf_pkg::REG_FRAME_HEIGHT, DW'(1));
		repeat (64) send_pixel(($urandom_range(3) == 0) ? ink_pixel() : WHITE_PIXEL);

		// blank frame
		set_frame(3, 3);
		send_frame(3, 3, INK_NONE);

		// zero width counts as one; latest blank row below ink sets the bottom
		set_frame(0, 4);
		send_pixel(rgb(8'hFF, 8'hFF, 8'h00));
		send_pixel(WHITE_PIXEL);
		send_pixel(rgb(8'h00, 8'h00, 8'h00));
		send_pixel(WHITE_PIXEL);

		// single near-white ink pixel in the middle
		set_frame(3, 3);
		repeat (4) send_pixel(WHITE_PIXEL);
		send_pixel(rgb(8'hFF, 8'hFE, 8'hFF));
		repeat (4) send_pixel(WHITE_PIXEL);

		// all ink
		set_frame(2, 2);
		send_pixel(rgb(8'hFE, 8'hFF, 8'hFF));
		send_pixel(rgb(8'hFF, 8'hFF, 8'hFE));
		send_pixel(rgb(8'h00, 8'hFF, 8'h00));
		send_pixel(rgb(8'h80, 8'h7F, 8'h01));

		// width and then height rewritten mid-frame
		set_frame(4, 4);
		repeat (3) send_pixel(WHITE_PIXEL);
		send_pixel(rgb(8'hFF, 8'h00, 8'hFF));
		repeat (2) send_pixel(WHITE_PIXEL);
		settle();
		write_reg(ibbf_pkg::REG_FRAME_WIDTH, DW'(2));
		send_pixel(WHITE_PIXEL);
		settle();
		write_reg(ibbf_pkg::REG_FRAME_HEIGHT, DW'(1));
		repeat (2) send_pixel(WHITE_PIXEL);

		// height shrunk below the first ink row, height wraps around
		set_frame(1, 8);
		repeat (5) send_pixel(WHITE_PIXEL);
		send_pixel(rgb(8'h10, 8'h20, 8'h30));
		settle();
		write_reg(ibbf_pkg::REG_FRAME_HEIGHT, DW'(2));
		send_pixel(ink_pixel());

		// random frames under each idle and stall mix
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 53; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 53; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			px0 = pixels_sent;
			while (pixels_sent - px0 < RANDOM_PIXELS) begin
				if ($urandom_range(9) == 0)
					broken_frame();
				else
					random_frame();
			end
		end

		// drain and give the verdict
		s_tvalid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending_count != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ ink_bounding_box_finder_unit.f @@
rtl/core/ibbf_pkg.sv
rtl/core/ibbf_pixel_in.sv
rtl/core/ibbf_tracker.sv
rtl/core/ibbf_out_reg.sv
rtl/core/ink_bounding_box_finder_unit.sv
tb/ibbf_box_checker.sv
tb/ink_bounding_box_finder_unit_tb.sv
